// File: hw/rtl/sbot_pkg.sv
// shared constants and controller/datapath types for the sparse block offset translator
`default_nettype none
package sbot_pkg;

  localparam int MAP_DEPTH    = 32768;
  localparam int HEADER_BYTES = 32768;
  localparam int MAX_SEGMENTS = 64;

  localparam int MAP_AW   = $clog2(MAP_DEPTH);
  localparam int PTR_W    = MAP_AW + 1;
  localparam int IDX_W    = 16;
  localparam int ENTRY_W  = IDX_W + 1;
  localparam int SEG_W    = $clog2(MAX_SEGMENTS + 1);

  localparam int BYTE_W   = 8;
  localparam int IN_OFF_W = 40;
  localparam int CNT_W    = 40;
  localparam int OFF_W    = 41;
  localparam int BS_W     = 25;
  localparam int DIV_CW   = $clog2(OFF_W);

  localparam logic [BS_W-1:0] BS_RESET = BS_W'(2097152);
  localparam logic [BS_W-1:0] BS_MAX   = BS_W'(16777216);

  localparam logic OP_LOAD      = 1'b0;
  localparam logic OP_TRANSLATE = 1'b1;

  typedef struct packed {
    logic load;
    logic accept;
    logic div_step;
    logic seg_read;
    logic seg_mul;
    logic seg_emit;
  } sbot_cmd_t;

  typedef struct packed {
    logic req_empty;
    logic div_last;
    logic seg_final;
  } sbot_status_t;

endpackage
`default_nettype wire

// File: hw/rtl/sbot_ram.sv
// generic single write port ram with registered read
`default_nettype none
module sbot_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: hw/rtl/sbot_ctrl.sv
// controller state machine sequencing load, division and segment output
`default_nettype none
module sbot_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic                  operation,
  input  wire sbot_pkg::sbot_status_t status,
  output sbot_pkg::sbot_cmd_t        cmd,
  output logic                       busy
);
  import sbot_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_READ = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (operation == OP_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.accept = 1'b1;
            if (!status.req_empty) begin
              state_next = ST_DIV;
            end
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        cmd.seg_read = 1'b1;
        state_next   = ST_MUL;
      end
      ST_MUL: begin
        cmd.seg_mul = 1'b1;
        state_next  = ST_OUT;
      end
      ST_OUT: begin
        cmd.seg_emit = 1'b1;
        state_next   = status.seg_final ? ST_IDLE : ST_READ;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule
`default_nettype wire

// File: hw/rtl/sbot_datapath.sv
// map storage, offset divider, segment arithmetic and result registers
`default_nettype none
module sbot_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire sbot_pkg::sbot_cmd_t           cmd,
  output sbot_pkg::sbot_status_t             status,
  input  wire logic                          block_bytes_we,
  input  wire logic [sbot_pkg::BS_W-1:0]     block_bytes,
  input  wire logic [sbot_pkg::BYTE_W-1:0]   map_byte,
  input  wire logic [sbot_pkg::IN_OFF_W-1:0] byte_offset,
  input  wire logic [sbot_pkg::CNT_W-1:0]    byte_count,
  output logic                               result_valid,
  output logic [sbot_pkg::OFF_W-1:0]         stored_offset,
  output logic [sbot_pkg::BS_W-1:0]          segment_length,
  output logic                               zero_fill,
  output logic                               truncated,
  output logic                               last_segment
);
  import sbot_pkg::*;

  logic [BS_W-1:0]    block_bytes_reg;
  logic [PTR_W-1:0]   load_pointer;
  logic [IDX_W-1:0]   present_count;
  logic [BS_W-1:0]    bs;
  logic [BS_W-1:0]    bs_eff;
  logic [OFF_W-1:0]   quot;
  logic [BS_W-1:0]    rem;
  logic [DIV_CW-1:0]  div_cnt;
  logic [CNT_W-1:0]   count;
  logic [BS_W-1:0]    seg_len;
  logic [SEG_W-1:0]   seg_cnt;
  logic [OFF_W-1:0]   product;
  logic               hit;
  logic               ram_we;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [BS_W:0]      rem_shift;
  logic               div_ge;
  logic [BS_W-1:0]    len_full;
  logic [CNT_W-1:0]   count_next;
  logic               seg_done;
  logic               seg_trunc;
  logic               present;

  sbot_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAP_DEPTH)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(load_pointer[MAP_AW-1:0]),
    .wdata(ram_wdata),
    .raddr(quot[MAP_AW-1:0]),
    .rdata(ram_rdata)
  );

  assign present   = (map_byte == BYTE_W'(1));
  assign ram_we    = cmd.load && !load_pointer[MAP_AW];
  assign ram_wdata = present ? {1'b1, present_count} : '0;

  always_comb begin
    bs_eff = block_bytes_reg;
    if (block_bytes_reg == '0) begin
      bs_eff = BS_W'(1);
    end else if (block_bytes_reg > BS_MAX) begin
      bs_eff = BS_MAX;
    end
  end

  // restoring division, one quotient bit per step
  assign rem_shift = {rem, quot[OFF_W-1]};
  assign div_ge    = (rem_shift >= {1'b0, bs});

  assign len_full   = bs - rem;
  assign count_next = count - CNT_W'(seg_len);
  assign seg_done   = (count_next == '0);
  assign seg_trunc  = !seg_done && (seg_cnt == SEG_W'(MAX_SEGMENTS - 1));

  assign status.req_empty = (byte_count == '0);
  assign status.div_last  = (div_cnt == DIV_CW'(OFF_W - 1));
  assign status.seg_final = seg_done || seg_trunc;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_bytes_reg <= BS_RESET;
      load_pointer    <= '0;
      present_count   <= '0;
      result_valid    <= 1'b0;
    end else begin
      result_valid <= (cmd.accept && status.req_empty) || cmd.seg_emit;
      if (block_bytes_we) begin
        block_bytes_reg <= block_bytes;
      end
      if (ram_we) begin
        load_pointer <= load_pointer + PTR_W'(1);
        if (present) begin
          present_count <= present_count + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      bs      <= bs_eff;
      quot    <= OFF_W'(byte_offset);
      rem     <= '0;
      div_cnt <= '0;
      count   <= byte_count;
      seg_cnt <= '0;
      if (status.req_empty) begin
        stored_offset  <= '0;
        segment_length <= '0;
        zero_fill      <= 1'b0;
        truncated      <= 1'b0;
        last_segment   <= 1'b1;
      end
    end
    if (cmd.div_step) begin
      rem     <= div_ge ? BS_W'(rem_shift - {1'b0, bs}) : rem_shift[BS_W-1:0];
      quot    <= {quot[OFF_W-2:0], div_ge};
      div_cnt <= div_cnt + DIV_CW'(1);
    end
    if (cmd.seg_read) begin
      seg_len <= (CNT_W'(len_full) > count) ? count[BS_W-1:0] : len_full;
    end
    if (cmd.seg_mul) begin
      product <= OFF_W'(ram_rdata[IDX_W-1:0]) * OFF_W'(bs);
      hit     <= (quot[OFF_W-1:MAP_AW] == '0) && ram_rdata[IDX_W];
    end
    if (cmd.seg_emit) begin
      stored_offset  <= hit ? (OFF_W'(HEADER_BYTES) + product + OFF_W'(rem)) : '0;
      segment_length <= seg_len;
      zero_fill      <= !hit;
      truncated      <= seg_trunc;
      last_segment   <= seg_done || seg_trunc;
      count          <= count_next;
      quot           <= quot + OFF_W'(1);
      rem            <= '0;
      seg_cnt        <= seg_cnt + SEG_W'(1);
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/sparse_block_offset_translator.sv
// top level: a load is done while busy stays low; a zero-length request gives its result
// in the cycle after acceptance; any other request holds busy through the divider steps
// and the read, multiply and output states of each segment, each result strobed for one
// cycle in the cycle after its segment ends; the receiver cannot stall
// reset clears the load pointer and the present count and sets the block size to 2097152;
// map contents are undefined until loaded
`default_nettype none
module sparse_block_offset_translator (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          block_bytes_we,
  input  wire logic [sbot_pkg::BS_W-1:0]     block_bytes,
  input  wire logic                          operation,
  input  wire logic [sbot_pkg::BYTE_W-1:0]   map_byte,
  input  wire logic [sbot_pkg::IN_OFF_W-1:0] byte_offset,
  input  wire logic [sbot_pkg::CNT_W-1:0]    byte_count,
  output logic                               result_valid,
  output logic [sbot_pkg::OFF_W-1:0]         stored_offset,
  output logic [sbot_pkg::BS_W-1:0]          segment_length,
  output logic                               zero_fill,
  output logic                               truncated,
  output logic                               last_segment
);
  import sbot_pkg::*;

  sbot_cmd_t    cmd;
  sbot_status_t status;

  sbot_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .operation(operation),
    .status   (status),
    .cmd      (cmd),
    .busy     (busy)
  );

  sbot_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .block_bytes_we(block_bytes_we),
    .block_bytes   (block_bytes),
    .map_byte      (map_byte),
    .byte_offset   (byte_offset),
    .byte_count    (byte_count),
    .result_valid  (result_valid),
    .stored_offset (stored_offset),
    .segment_length(segment_length),
    .zero_fill     (zero_fill),
    .truncated     (truncated),
    .last_segment  (last_segment)
  );

endmodule
`default_nettype wire
